/* rtl/omsm_pkg.sv */
// Shared constants, widths and controller/datapath command types for the
// online mean / standard deviation / maximum block. No dependencies.
`default_nettype none

package omsm_pkg;

    // Field and state widths
    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 16;
    localparam int FIX_W       = SAMPLE_BITS + FRAC_BITS;
    localparam int COUNT_W     = 32;
    localparam int SUM_W       = 64;

    // Iterative unit widths
    localparam int PROD_W      = 2 * FIX_W;
    localparam int RAD_W       = SUM_W + FRAC_BITS;
    localparam int ROOT_W      = (RAD_W + 1) / 2;
    localparam int REM_W       = ROOT_W + 3;
    localparam int STEP_W      = $clog2(SUM_W);

    // Divider operand select
    localparam logic DIV_MEAN = 1'b0;
    localparam logic DIV_VAR  = 1'b1;

    // Controller to datapath commands (one step pulse per cycle)
    typedef struct packed {
        logic load;
        logic div_init;
        logic div_sel;
        logic div_step;
        logic mean_upd;
        logic mul_init;
        logic mul_step;
        logic acc;
        logic sqrt_init;
        logic sqrt_step;
        logic dev_upd;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic n_gt1;
    } t_dp_sts;

endpackage

`default_nettype wire

/* rtl/omsm_if.sv */
// Valid/ready channel interfaces for sample input items and statistics
// result items. Depends on omsm_pkg.
`default_nettype none

interface omsm_in_if import omsm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface omsm_out_if import omsm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [COUNT_W-1:0]     sample_count;
    logic [FIX_W-1:0]       mean_value;
    logic [FIX_W-1:0]       std_deviation;
    logic [SAMPLE_BITS-1:0] max_sample;

    modport source (output valid, output sample_count, output mean_value,
                    output std_deviation, output max_sample, input ready);
    modport sink   (input valid, input sample_count, input mean_value,
                    input std_deviation, input max_sample, output ready);
endinterface

`default_nettype wire

/* rtl/omsm_dp.sv */
// Datapath: statistics state, shared radix-2 divider, shift-add multiplier,
// digit-by-digit square root and the output register. Depends on omsm_pkg.
`default_nettype none

module omsm_dp import omsm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic [COUNT_W-1:0]     o_sample_count,
    output logic [FIX_W-1:0]       o_mean_value,
    output logic [FIX_W-1:0]       o_std_deviation,
    output logic [SAMPLE_BITS-1:0] o_max_sample
);

    // Statistics state
    logic [COUNT_W-1:0]     r_count;
    logic [FIX_W-1:0]       r_mean;
    logic [SUM_W-1:0]       r_sum;
    logic [FIX_W-1:0]       r_dev;
    logic [SAMPLE_BITS-1:0] r_max;

    // Per-item working registers
    logic [FIX_W-1:0]       r_x;
    logic                   r_up;
    logic [FIX_W-1:0]       r_d1;
    logic [SUM_W-1:0]       r_quo;
    logic [COUNT_W-1:0]     r_rem;
    logic [COUNT_W-1:0]     r_dsr;
    logic [PROD_W-1:0]      r_prod;
    logic [2*ROOT_W-1:0]    r_rad;
    logic [ROOT_W-1:0]      r_root;
    logic [REM_W-1:0]       r_srem;

    // Output register
    logic [COUNT_W-1:0]     r_out_count;
    logic [FIX_W-1:0]       r_out_mean;
    logic [FIX_W-1:0]       r_out_dev;
    logic [SAMPLE_BITS-1:0] r_out_max;

    logic [FIX_W-1:0]        x_new;
    logic [FIX_W:0]          diff_up;
    logic [FIX_W-1:0]        diff_dn;
    logic                    up_new;
    logic [COUNT_W:0]        rem_sh;
    logic                    div_ge;
    logic [COUNT_W:0]        rem_nxt;
    logic [FIX_W-1:0]        mean_q;
    logic [FIX_W-1:0]        d2;
    logic [FIX_W:0]          mul_sum;
    logic [PROD_W+SUM_W-1:0] prod_ext;
    logic                    prod_ovf;
    logic [SUM_W:0]          sum_wide;
    logic [REM_W-1:0]        srem_sh;
    logic [REM_W-1:0]        trial;
    logic                    sqrt_ge;
    logic [ROOT_W+FIX_W-1:0] root_ext;
    logic                    root_ovf;

    // Scaled sample and |x - mean| against the old mean
    assign x_new   = {i_sample, {FRAC_BITS{1'b0}}};
    assign diff_up = {1'b0, x_new} - {1'b0, r_mean};
    assign diff_dn = r_mean - x_new;
    assign up_new  = ~diff_up[FIX_W];

    // Restoring divider step
    assign rem_sh  = {r_rem, r_quo[SUM_W-1]};
    assign div_ge  = rem_sh >= {1'b0, r_dsr};
    assign rem_nxt = div_ge ? (rem_sh - {1'b0, r_dsr}) : rem_sh;
    assign mean_q  = r_quo[FIX_W-1:0];

    // Deviation against the new mean
    assign d2 = r_up ? (r_x - r_mean) : (r_mean - r_x);

    // Shift-add multiplier step: multiplier bits sit in the low half
    assign mul_sum = {1'b0, r_prod[PROD_W-1:FIX_W]}
                   + (r_prod[0] ? {1'b0, r_d1} : {(FIX_W+1){1'b0}});

    // Product scaled back to FRAC_BITS, saturating into the sum
    assign prod_ext = {{SUM_W{1'b0}}, r_prod} >> FRAC_BITS;
    assign prod_ovf = |prod_ext[PROD_W+SUM_W-1:SUM_W];
    assign sum_wide = {1'b0, r_sum} + {1'b0, prod_ext[SUM_W-1:0]};

    // Square root step, two radicand bits per step
    assign srem_sh = {r_srem[REM_W-3:0], r_rad[2*ROOT_W-1 -: 2]};
    assign trial   = {1'b0, r_root, 2'b01};
    assign sqrt_ge = srem_sh >= trial;

    // Root clipped to the output width
    assign root_ext = {{FIX_W{1'b0}}, r_root};
    assign root_ovf = |root_ext[ROOT_W+FIX_W-1:FIX_W];

    // Statistics state, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_mean  <= '0;
            r_sum   <= '0;
            r_dev   <= '0;
            r_max   <= '0;
        end else begin
            if (i_cmd.load) begin
                if (!(&r_count)) begin
                    r_count <= r_count + 1'b1;
                end
                if (i_sample > r_max) begin
                    r_max <= i_sample;
                end
            end
            if (i_cmd.mean_upd) begin
                r_mean <= r_up ? (r_mean + mean_q) : (r_mean - mean_q);
            end
            if (i_cmd.acc) begin
                r_sum <= (prod_ovf || sum_wide[SUM_W]) ? {SUM_W{1'b1}}
                                                       : sum_wide[SUM_W-1:0];
            end
            if (i_cmd.dev_upd) begin
                r_dev <= root_ovf ? {FIX_W{1'b1}} : root_ext[FIX_W-1:0];
            end
        end
    end

    // Working registers of the iterative units
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x  <= x_new;
            r_up <= up_new;
            r_d1 <= up_new ? diff_up[FIX_W-1:0] : diff_dn;
        end
        if (i_cmd.div_init) begin
            r_rem <= '0;
            if (i_cmd.div_sel == DIV_VAR) begin
                r_quo <= r_sum;
                r_dsr <= r_count - 1'b1;
            end else begin
                r_quo <= {r_d1, {(SUM_W-FIX_W){1'b0}}};
                r_dsr <= r_count;
            end
        end else if (i_cmd.div_step) begin
            r_rem <= rem_nxt[COUNT_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], div_ge};
        end
        if (i_cmd.mul_init) begin
            r_prod <= {{FIX_W{1'b0}}, d2};
        end else if (i_cmd.mul_step) begin
            r_prod <= {mul_sum, r_prod[FIX_W-1:1]};
        end
        if (i_cmd.sqrt_init) begin
            r_rad  <= (2*ROOT_W)'({r_quo, {FRAC_BITS{1'b0}}});
            r_root <= '0;
            r_srem <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_rad  <= {r_rad[2*ROOT_W-3:0], 2'b00};
            r_root <= {r_root[ROOT_W-2:0], sqrt_ge};
            r_srem <= sqrt_ge ? (srem_sh - trial) : srem_sh;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_count <= r_count;
            r_out_mean  <= r_mean;
            r_out_dev   <= r_dev;
            r_out_max   <= r_max;
        end
    end

    assign o_sts.n_gt1     = |r_count[COUNT_W-1:1];
    assign o_sample_count  = r_out_count;
    assign o_mean_value    = r_out_mean;
    assign o_std_deviation = r_out_dev;
    assign o_max_sample    = r_out_max;

endmodule

`default_nettype wire

/* rtl/omsm_ctrl.sv */
// Controller: sequences the datapath through load, divide, mean update, multiply,
// accumulate, then divide and square root when n > 1, then output. Depends on omsm_pkg.
`default_nettype none

module omsm_ctrl import omsm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DIV1_INIT = 4'd1;
    localparam logic [3:0] S_DIV1      = 4'd2;
    localparam logic [3:0] S_MEAN      = 4'd3;
    localparam logic [3:0] S_D2        = 4'd4;
    localparam logic [3:0] S_MUL       = 4'd5;
    localparam logic [3:0] S_ACC       = 4'd6;
    localparam logic [3:0] S_DIV2_INIT = 4'd7;
    localparam logic [3:0] S_DIV2      = 4'd8;
    localparam logic [3:0] S_SQRT_INIT = 4'd9;
    localparam logic [3:0] S_SQRT      = 4'd10;
    localparam logic [3:0] S_DEV       = 4'd11;
    localparam logic [3:0] S_DONE      = 4'd12;

    logic [3:0]        r_state;
    logic [3:0]        n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              r_out_valid;
    logic              n_out_valid;
    t_dp_cmd           cmd;
    logic              last_step;

    assign last_step = (r_step == '0);

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DIV1_INIT;
                end
            end
            S_DIV1_INIT: begin
                cmd.div_init = 1'b1;
                cmd.div_sel  = DIV_MEAN;
                n_step       = STEP_W'(FIX_W - 1);
                n_state      = S_DIV1;
            end
            S_DIV1: begin
                cmd.div_step = 1'b1;
                n_step       = r_step - 1'b1;
                if (last_step) begin
                    n_state = S_MEAN;
                end
            end
            S_MEAN: begin
                cmd.mean_upd = 1'b1;
                n_state      = S_D2;
            end
            S_D2: begin
                cmd.mul_init = 1'b1;
                n_step       = STEP_W'(FIX_W - 1);
                n_state      = S_MUL;
            end
            S_MUL: begin
                cmd.mul_step = 1'b1;
                n_step       = r_step - 1'b1;
                if (last_step) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                cmd.acc = 1'b1;
                n_state = i_sts.n_gt1 ? S_DIV2_INIT : S_DONE;
            end
            S_DIV2_INIT: begin
                cmd.div_init = 1'b1;
                cmd.div_sel  = DIV_VAR;
                n_step       = STEP_W'(SUM_W - 1);
                n_state      = S_DIV2;
            end
            S_DIV2: begin
                cmd.div_step = 1'b1;
                n_step       = r_step - 1'b1;
                if (last_step) begin
                    n_state = S_SQRT_INIT;
                end
            end
            S_SQRT_INIT: begin
                cmd.sqrt_init = 1'b1;
                n_step        = STEP_W'(ROOT_W - 1);
                n_state       = S_SQRT;
            end
            S_SQRT: begin
                cmd.sqrt_step = 1'b1;
                n_step        = r_step - 1'b1;
                if (last_step) begin
                    n_state = S_DEV;
                end
            end
            S_DEV: begin
                cmd.dev_upd = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid flag
    always_comb begin
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

`default_nettype wire

/* rtl/online_mean_stddev_max_core.sv */
// Running latency statistics (Welford mean and sample standard deviation,
// 16 fractional bits) plus sample count and maximum, one result item per
// sample item. One item is worked on at a time: it is taken when the
// controller is idle and runs through a shared one-bit-per-cycle divider, a
// one-bit-per-cycle multiplier and a two-bit-per-cycle square root. The mean
// division and the product work through the sample plus fraction width,
// the variance division through the sum width and the square root through
// half the radicand width; the variance division and the square root are
// skipped while fewer than two samples have been seen. The next item can
// be taken in the cycle after the result enters the output register.
// The output register holds a finished result while the next item is
// already being computed; a result whose register is still full waits.
// Depends on omsm_pkg, omsm_if, omsm_ctrl and omsm_dp.
`default_nettype none

module online_mean_stddev_max_core import omsm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    omsm_in_if.sink           i_in,
    omsm_out_if.source        o_out
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;
    logic    w_out_valid;

    omsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (w_out_valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    omsm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_sample        (i_in.sample),
        .o_sample_count  (o_out.sample_count),
        .o_mean_value    (o_out.mean_value),
        .o_std_deviation (o_out.std_deviation),
        .o_max_sample    (o_out.max_sample)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

    // A sample is loaded only on an accepted input item
    a_load_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> (i_in.valid && i_in.ready))
        else $error("sample loaded without an accepted item");

    // A result never overwrites one that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_out.valid || o_out.ready))
        else $error("pending result overwritten");

    // At most one datapath step per cycle
    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.div_init, w_cmd.div_step, w_cmd.mean_upd,
                  w_cmd.mul_init, w_cmd.mul_step, w_cmd.acc, w_cmd.sqrt_init,
                  w_cmd.sqrt_step, w_cmd.dev_upd, w_cmd.out_load}))
        else $error("overlapping datapath commands");

    // An accepted item blocks the input while it is being worked on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input ready while an item is in progress");

endmodule

`default_nettype wire
